[hw/rtl/cpsc_pkg.sv]
// ----------------------------------------------------------------------------
// cpsc_pkg : shared definitions for the complex phase scaler
// Widths, CORDIC arctangent table, inverse gain, register codes and the
// data and tag structures that travel along the cell chains.
// ----------------------------------------------------------------------------
package cpsc_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int CORDIC_STAGES   = 16;
   localparam int RATIO_FRAC_BITS = 16;

   localparam int NUM_STAGES  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int STAGE_IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   localparam int GUARD     = 36 - SAMPLE_WIDTH;
   localparam int XY_W      = SAMPLE_WIDTH + GUARD + 4;
   localparam int PHASE_W   = 32;
   localparam int Z_W       = PHASE_W + 2;
   localparam int RATIO_W   = 32;
   localparam int OUT_W     = SAMPLE_WIDTH + 2;
   localparam int GAIN_BITS = 24;
   localparam int GAIN_W    = GAIN_BITS + 1;
   localparam int SAT_W     = 48;

   localparam int REQ_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(1) <<< (PHASE_W - 2);

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(2) << RATIO_FRAC_BITS;
   localparam logic               MODE_RESET  = 1'b1;

   localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((2 ** (OUT_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] OUT_MIN = SAT_W'(-(2 ** (OUT_W - 1)));

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PHASE_RATIO  = 1'b0,
      REG_COMPLEX_MODE = 1'b1
   } csr_reg_type;

   // atan(2^-i) as a fraction of a turn, 2^32 units per turn
   localparam logic [PHASE_W-1:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Inverse gain of both passes after n stages, 2^24 = unity
   localparam logic [GAIN_W-1:0] INV_GAIN [0:32] = '{
      25'd16777216, 25'd8388608, 25'd6710887, 25'd6316129,
      25'd6218958,  25'd6194760, 25'd6188717, 25'd6187207,
      25'd6186830,  25'd6186736, 25'd6186713, 25'd6186708,
      25'd6186707,  25'd6186707, 25'd6186707, 25'd6186707,
      25'd6186707,  25'd6186707, 25'd6186707, 25'd6186707,
      25'd6186707,  25'd6186707, 25'd6186707, 25'd6186707,
      25'd6186707,  25'd6186707, 25'd6186707, 25'd6186707,
      25'd6186707,  25'd6186707, 25'd6186707, 25'd6186707,
      25'd6186707
   };

   localparam logic [GAIN_W-1:0] INV_GAIN_N = INV_GAIN[NUM_STAGES];

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   typedef struct packed {
      logic                           cmode;
      logic signed [SAMPLE_WIDTH-1:0] re;
   } tag_type;

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
      logic [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/cpsc_cell.sv]
// ----------------------------------------------------------------------------
// cpsc_cell : one CORDIC micro-rotation
// Registered stage; vectoring steers y to zero, rotation steers z to zero.
// ----------------------------------------------------------------------------
module cpsc_cell (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      rotate,
   input  logic [cpsc_pkg::STAGE_IDX_W-1:0]          shift,
   input  logic [cpsc_pkg::PHASE_W-1:0]              angle,
   input  logic                                      in_valid,
   input  cpsc_pkg::tag_type                         in_tag,
   input  cpsc_pkg::cordic_type                      in_data,
   output logic                                      out_valid,
   output cpsc_pkg::tag_type                         out_tag,
   output cpsc_pkg::cordic_type                      out_data
);

   logic signed [cpsc_pkg::XY_W-1:0] xi, yi, dx, dy;
   logic signed [cpsc_pkg::Z_W-1:0]  zi, ang;
   logic                             cw;
   cpsc_pkg::cordic_type             step;

   logic                 valid_ff;
   cpsc_pkg::tag_type    tag_ff;
   cpsc_pkg::cordic_type data_ff;

   always_comb begin
      xi  = in_data.x;
      yi  = in_data.y;
      zi  = in_data.z;
      dx  = yi >>> shift;
      dy  = xi >>> shift;
      ang = $signed({{(cpsc_pkg::Z_W - cpsc_pkg::PHASE_W){1'b0}}, angle});
      // vectoring with y >= 0 and rotation with z < 0 turn the same way
      cw  = rotate ? zi[cpsc_pkg::Z_W-1] : ~yi[cpsc_pkg::XY_W-1];
      if (cw) begin
         step.x = xi + dx;
         step.y = yi - dy;
         step.z = zi + ang;
      end else begin
         step.x = xi - dx;
         step.y = yi + dy;
         step.z = zi - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff  <= in_tag;
         data_ff <= step;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/cpsc_phase.sv]
// ----------------------------------------------------------------------------
// cpsc_phase : phase scaling between the two CORDIC chains
// Multiplies the phase by the ratio modulo one turn, then folds the result
// into +-1/4 turn, negating the magnitude where a half turn is removed.
// ----------------------------------------------------------------------------
module cpsc_phase (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic signed [cpsc_pkg::RATIO_W-1:0]  ratio,
   input  logic                                 in_valid,
   input  cpsc_pkg::tag_type                    in_tag,
   input  cpsc_pkg::cordic_type                 in_data,
   output logic                                 out_valid,
   output cpsc_pkg::tag_type                    out_tag,
   output cpsc_pkg::cordic_type                 out_data
);

   localparam int F     = cpsc_pkg::RATIO_FRAC_BITS;
   localparam int LO_W  = cpsc_pkg::Z_W + F + 1;
   localparam int HI_W  = cpsc_pkg::Z_W + cpsc_pkg::RATIO_W - F;
   localparam int SUM_W = F + cpsc_pkg::PHASE_W;
   localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (F - 1);

   logic signed [cpsc_pkg::Z_W-1:0]  zi;
   logic signed [HI_W-1:0]           hi_full;
   logic [SUM_W-1:0]                 psum;
   logic [cpsc_pkg::PHASE_W-1:0]     q, qf;
   cpsc_pkg::cordic_type             folded;

   // first stage: partial products
   logic                             p1_valid_ff;
   cpsc_pkg::tag_type                p1_tag_ff;
   logic signed [cpsc_pkg::XY_W-1:0] p1_x_ff;
   logic signed [LO_W-1:0]           p1_lo_ff;
   logic [cpsc_pkg::PHASE_W-1:0]     p1_hi_ff;

   // second stage: folded rotation start
   logic                             p2_valid_ff;
   cpsc_pkg::tag_type                p2_tag_ff;
   cpsc_pkg::cordic_type             p2_data_ff;

   always_comb begin
      zi      = in_data.z;
      hi_full = zi * $signed(ratio[cpsc_pkg::RATIO_W-1:F]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_tag_ff  <= in_tag;
         p1_x_ff    <= in_data.x;
         p1_lo_ff   <= zi * $signed({1'b0, ratio[F-1:0]});
         p1_hi_ff   <= hi_full[cpsc_pkg::PHASE_W-1:0];
         p2_tag_ff  <= p1_tag_ff;
         p2_data_ff <= folded;
      end
   end

   always_comb begin
      // only the low turn bits of the product matter
      psum = p1_lo_ff[SUM_W-1:0] + {p1_hi_ff, {F{1'b0}}} + ROUND;
      q    = psum[SUM_W-1:F];
      qf   = q;
      folded.x = p1_x_ff;
      folded.y = '0;
      if (q[cpsc_pkg::PHASE_W-1] ^ q[cpsc_pkg::PHASE_W-2]) begin
         folded.x = -p1_x_ff;
         qf       = {~q[cpsc_pkg::PHASE_W-1], q[cpsc_pkg::PHASE_W-2:0]};
      end
      folded.z = $signed({{(cpsc_pkg::Z_W - cpsc_pkg::PHASE_W){qf[cpsc_pkg::PHASE_W-1]}}, qf});
   end

   assign out_valid = p2_valid_ff;
   assign out_tag   = p2_tag_ff;
   assign out_data  = p2_data_ff;

endmodule

[hw/rtl/cpsc_post.sv]
// ----------------------------------------------------------------------------
// cpsc_post : gain correction, real-mode scaling and output buffering
// Removes the CORDIC gain, rounds and saturates, and holds results in an
// output register with a skid stage so the pipeline can keep moving.
// ----------------------------------------------------------------------------
module cpsc_post (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [cpsc_pkg::RATIO_W-1:0]     ratio,
   input  logic                                    in_valid,
   input  cpsc_pkg::tag_type                       in_tag,
   input  cpsc_pkg::cordic_type                    in_data,
   output logic                                    advance,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [cpsc_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int GLO_W     = cpsc_pkg::GAIN_W - cpsc_pkg::GAIN_W / 2;
   localparam int GHI_W     = cpsc_pkg::GAIN_W - GLO_W;
   localparam int XLO_W     = cpsc_pkg::XY_W + GLO_W + 1;
   localparam int XHI_W     = cpsc_pkg::XY_W + GHI_W + 1;
   localparam int XSUM_W    = cpsc_pkg::XY_W + cpsc_pkg::GAIN_W + 1;
   localparam int OUT_SHIFT = cpsc_pkg::GAIN_BITS + cpsc_pkg::GUARD;
   localparam int REAL_W    = cpsc_pkg::SAMPLE_WIDTH + cpsc_pkg::RATIO_W;
   localparam int F         = cpsc_pkg::RATIO_FRAC_BITS;
   localparam int PAD_W     = cpsc_pkg::RSP_TDATA_W - 2 * cpsc_pkg::OUT_W;

   localparam logic signed [XSUM_W-1:0] XSUM_ROUND = XSUM_W'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [REAL_W-1:0] REAL_ROUND = REAL_W'(1) <<< (F - 1);
   localparam logic [GLO_W-1:0] GAIN_LO = cpsc_pkg::INV_GAIN_N[GLO_W-1:0];
   localparam logic [GHI_W-1:0] GAIN_HI = cpsc_pkg::INV_GAIN_N[cpsc_pkg::GAIN_W-1:GLO_W];

   logic signed [cpsc_pkg::XY_W-1:0] xi, yi;

   logic                     a_valid_ff;
   logic                     a_mode_ff;
   logic signed [XLO_W-1:0]  xlo_ff, ylo_ff;
   logic signed [XHI_W-1:0]  xhi_ff, yhi_ff;
   logic signed [REAL_W-1:0] real_ff;

   logic signed [XSUM_W-1:0] xsum, ysum, xsh, ysh;
   logic signed [REAL_W-1:0] rsum, rsh;
   logic [cpsc_pkg::OUT_W-1:0] res_re, res_im;
   logic [cpsc_pkg::RSP_TDATA_W-1:0] word;
   logic push, take;

   logic rsp_valid_ff, rsp_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic [cpsc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [cpsc_pkg::RSP_TDATA_W-1:0] skid_data_ff, skid_data_in;

   assign advance = ~skid_valid_ff;
   assign xi      = in_data.x;
   assign yi      = in_data.y;

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mode_ff <= in_tag.cmode;
         xlo_ff    <= xi * $signed({1'b0, GAIN_LO});
         xhi_ff    <= xi * $signed({1'b0, GAIN_HI});
         ylo_ff    <= yi * $signed({1'b0, GAIN_LO});
         yhi_ff    <= yi * $signed({1'b0, GAIN_HI});
         real_ff   <= in_tag.re * ratio;
      end
   end

   // sum, round half up, saturate
   always_comb begin
      xsum   = (XSUM_W'(xhi_ff) <<< GLO_W) + XSUM_W'(xlo_ff) + XSUM_ROUND;
      ysum   = (XSUM_W'(yhi_ff) <<< GLO_W) + XSUM_W'(ylo_ff) + XSUM_ROUND;
      xsh    = xsum >>> OUT_SHIFT;
      ysh    = ysum >>> OUT_SHIFT;
      rsum   = real_ff + REAL_ROUND;
      rsh    = rsum >>> F;
      if (a_mode_ff) begin
         res_re = cpsc_pkg::sat_out(xsh[cpsc_pkg::SAT_W-1:0]);
         res_im = cpsc_pkg::sat_out(ysh[cpsc_pkg::SAT_W-1:0]);
      end else begin
         res_re = cpsc_pkg::sat_out(cpsc_pkg::SAT_W'(rsh));
         res_im = '0;
      end
      word = {{PAD_W{1'b0}}, res_im, res_re};
   end

   // output register with skid stage
   always_comb begin
      push          = advance & a_valid_ff;
      take          = ~rsp_valid_ff | rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         rsp_valid_in = push;
         rsp_data_in  = word;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/complex_phase_scaler.sv]
// ----------------------------------------------------------------------------
// complex_phase_scaler : CORDIC phase multiplier for Q1.15 complex samples
// Every CORDIC cell in both chains is its own pipeline stage.
// Throughput: one sample per clock while the output skid stage is empty.
// Reset (synchronous): clears valid and skid flags; ratio 2.0, complex mode.
// ----------------------------------------------------------------------------
module complex_phase_scaler (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: sample_re [15:0], sample_im [31:16]
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [cpsc_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // rsp_tdata: result_re [17:0], result_im [35:18], zero [39:36]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cpsc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cpsc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cpsc_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int N  = cpsc_pkg::NUM_STAGES;
   localparam int SW = cpsc_pkg::SAMPLE_WIDTH;

   logic                              en;
   logic signed [SW-1:0]              req_re, req_im;
   logic signed [cpsc_pkg::XY_W-1:0]  re_x, im_x;
   cpsc_pkg::cordic_type              pre;
   cpsc_pkg::tag_type                 pre_tag;

   logic [cpsc_pkg::RATIO_W-1:0] ratio_ff, ratio_in;
   logic                         mode_ff, mode_in;

   logic                 vec_valid [0:N];
   cpsc_pkg::tag_type    vec_tag   [0:N];
   cpsc_pkg::cordic_type vec_data  [0:N];
   logic                 rot_valid [0:N];
   cpsc_pkg::tag_type    rot_tag   [0:N];
   cpsc_pkg::cordic_type rot_data  [0:N];

   logic                 s0_valid_ff;
   cpsc_pkg::tag_type    s0_tag_ff;
   cpsc_pkg::cordic_type s0_data_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = en;

   // configuration registers
   always_comb begin
      ratio_in = ratio_ff;
      mode_in  = mode_ff;
      if (csr_valid) begin
         case (cpsc_pkg::csr_reg_type'(csr_index))
            cpsc_pkg::REG_PHASE_RATIO:  ratio_in = csr_data[cpsc_pkg::RATIO_W-1:0];
            cpsc_pkg::REG_COMPLEX_MODE: mode_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= cpsc_pkg::RATIO_RESET;
         mode_ff  <= cpsc_pkg::MODE_RESET;
      end else begin
         ratio_ff <= ratio_in;
         mode_ff  <= mode_in;
      end
   end

   // input stage: left half-plane samples get a quarter-turn pre-rotation
   always_comb begin
      req_re = req_tdata[SW-1:0];
      req_im = req_tdata[2*SW-1:SW];
      re_x   = cpsc_pkg::XY_W'(req_re) <<< cpsc_pkg::GUARD;
      im_x   = cpsc_pkg::XY_W'(req_im) <<< cpsc_pkg::GUARD;
      pre.x  = re_x;
      pre.y  = im_x;
      pre.z  = '0;
      if (req_re[SW-1]) begin
         if (!req_im[SW-1]) begin
            pre.x = im_x;
            pre.y = -re_x;
            pre.z = cpsc_pkg::Z_QUARTER;
         end else begin
            pre.x = -im_x;
            pre.y = re_x;
            pre.z = -cpsc_pkg::Z_QUARTER;
         end
      end
      pre_tag.cmode = mode_ff;
      pre_tag.re    = req_re;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_tag_ff  <= pre_tag;
         s0_data_ff <= pre;
      end
   end

   assign vec_valid[0] = s0_valid_ff;
   assign vec_tag[0]   = s0_tag_ff;
   assign vec_data[0]  = s0_data_ff;

   // vectoring chain
   for (genvar k = 0; k < N; k++) begin : g_vec
      cpsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .rotate    (1'b0),
         .shift     (cpsc_pkg::STAGE_IDX_W'(k)),
         .angle     (cpsc_pkg::ATAN_TURNS[k]),
         .in_valid  (vec_valid[k]),
         .in_tag    (vec_tag[k]),
         .in_data   (vec_data[k]),
         .out_valid (vec_valid[k+1]),
         .out_tag   (vec_tag[k+1]),
         .out_data  (vec_data[k+1])
      );
   end

   cpsc_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ratio     ($signed(ratio_ff)),
      .in_valid  (vec_valid[N]),
      .in_tag    (vec_tag[N]),
      .in_data   (vec_data[N]),
      .out_valid (rot_valid[0]),
      .out_tag   (rot_tag[0]),
      .out_data  (rot_data[0])
   );

   // rotation chain
   for (genvar k = 0; k < N; k++) begin : g_rot
      cpsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .rotate    (1'b1),
         .shift     (cpsc_pkg::STAGE_IDX_W'(k)),
         .angle     (cpsc_pkg::ATAN_TURNS[k]),
         .in_valid  (rot_valid[k]),
         .in_tag    (rot_tag[k]),
         .in_data   (rot_data[k]),
         .out_valid (rot_valid[k+1]),
         .out_tag   (rot_tag[k+1]),
         .out_data  (rot_data[k+1])
      );
   end

   cpsc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .ratio      ($signed(ratio_ff)),
      .in_valid   (rot_valid[N]),
      .in_tag     (rot_tag[N]),
      .in_data    (rot_data[N]),
      .advance    (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hw/rtl/cpsc_checker.sv]
// ----------------------------------------------------------------------------
// cpsc_checker : port-level checks for the complex phase scaler
// Watches the stream handshakes and result data; bound to the top level.
// ----------------------------------------------------------------------------
module cpsc_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tready,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [cpsc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   // a stalled result transaction holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // input back-pressure only when a result is waiting
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a waiting result");

   // an empty output register means the skid stage cannot be full
   a_ready_after_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |=> req_tready)
      else $error("req_tready low after an idle output");

endmodule

bind complex_phase_scaler cpsc_checker u_checker (.*);
